/* rtl/gos_pkg.sv */
// Package for the grid obstacle section selector.
// Holds widths, register codes, reset values and the small helper functions.
// No dependencies.
package gos_pkg;

    // Field and counter widths.
    localparam int SIZE_W    = 12;
    localparam int POS_W     = 11;
    localparam int PIX_W     = 8;
    localparam int PCT_W     = 7;
    localparam int CNT_W     = 19;
    localparam int CELL_W    = 4;
    localparam int NUM_CELLS = 9;
    localparam int DIV_W     = CNT_W + 7;

    // Frame size limits.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_SIZE   = 3;

    // Register reset values.
    localparam int RST_WIDTH     = 720;
    localparam int RST_HEIGHT    = 404;
    localparam int RST_DISP_THR  = 120;
    localparam int RST_PCT_THR   = 20;

    // Band borders that follow from the reset size.
    localparam int RST_COL_B1 = RST_WIDTH / 3;
    localparam int RST_COL_B2 = (2 * RST_WIDTH) / 3;
    localparam int RST_ROW_B1 = RST_HEIGHT / 3;
    localparam int RST_ROW_B2 = (2 * RST_HEIGHT) / 3;

    // Special grid cells and percentages.
    localparam logic [CELL_W-1:0] CENTRE_CELL = CELL_W'(4);
    localparam logic [CELL_W-1:0] LAST_CELL   = CELL_W'(NUM_CELLS - 1);
    localparam logic [PCT_W-1:0]  FULL_PCT    = PCT_W'(100);

    // Register map, one 32-bit word per register.
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_DISP_THR     = 2'd2,
        REG_PCT_THR      = 2'd3
    } reg_idx_t;

    // One counter memory entry.
    typedef struct packed {
        logic [CNT_W-1:0] near;
        logic [CNT_W-1:0] total;
    } cell_count_t;

    // Band borders and last position for one frame dimension.
    typedef struct packed {
        logic [POS_W-1:0] last;
        logic [POS_W-1:0] b1;
        logic [POS_W-1:0] b2;
    } dim_geom_t;

    // Clamp a frame size to the supported range.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        begin
            r = v;
            if (v < SIZE_W'(MIN_SIZE))
            begin
                r = SIZE_W'(MIN_SIZE);
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

    // Floor of x/3 by multiplying with the reciprocal, exact for x below 2^16.
    function automatic logic [POS_W-1:0] div3(input logic [SIZE_W:0] x);
        logic [SIZE_W+16:0] prod;
        begin
            prod = {16'd0, x} * {{(SIZE_W+1){1'b0}}, 16'hAAAB};
            return prod[POS_W+16:17];
        end
    endfunction

    // Borders and last position for a clamped size.
    function automatic dim_geom_t make_geom(input logic [SIZE_W-1:0] raw,
                                            input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] s;
        logic [SIZE_W-1:0] sm1;
        dim_geom_t g;
        begin
            s      = clamp_size(raw, hi);
            sm1    = s - SIZE_W'(1);
            g.last = sm1[POS_W-1:0];
            g.b1   = div3({1'b0, s});
            g.b2   = div3({s, 1'b0});
            return g;
        end
    endfunction

endpackage

/* rtl/grid_obstacle_section_select.sv */
// Top level of the grid obstacle section selector.
// Depends on gos_pkg for widths, register codes and the border helpers.
//
// Pixels of a disparity frame arrive in raster order, one per beat, and are
// sorted into a 3x3 grid; the block accepts one pixel per cycle during a frame.
// Per-cell pixel and near-pixel counts live in a nine-entry counter memory
// that is read, incremented and written back in a two-stage pipeline with
// forwarding for back-to-back hits on one cell. After the last pixel of a
// frame the input stalls while the last write retires, during a pass over
// the nine cells (read, operand load, seven steps of a one-bit-per-cycle
// divider for the percentage, update of the centre value or the minimum)
// and while the result beat is loaded, longer if the previous result has
// not been taken. The result register lets the next frame start while the
// result still waits. Entry valid bits are cleared at reset and on each
// result load, so stale counters read as zero and no clearing pass is needed.
module grid_obstacle_section_select (
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Pixel channel.
    input  logic                       pixel_valid,
    output logic                       pixel_ready,
    input  logic [gos_pkg::PIX_W-1:0]  pixel_value,
    // Result channel.
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [gos_pkg::CELL_W-1:0] chosen_cell,
    output logic                       cell_found,
    output logic [gos_pkg::PCT_W-1:0]  chosen_percent
);
    import gos_pkg::*;

    typedef enum logic [5:0] {
        S_PIXEL = 6'b000001,
        S_DRAIN = 6'b000010,
        S_READ  = 6'b000100,
        S_LOAD  = 6'b001000,
        S_DIV   = 6'b010000,
        S_SEL   = 6'b100000
    } state_t;

    // Output phase flag: the result register is loaded while it is set, and it holds the pixel input off.
    logic out_phase_reg;

    state_t                state_reg, state_next;

    // Configuration registers.
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [PIX_W-1:0]      disp_thr_reg;
    logic [PCT_W-1:0]      pct_thr_reg;
    dim_geom_t             col_geom_reg;
    dim_geom_t             row_geom_reg;

    // Raster position.
    logic [POS_W-1:0]      col_pos_reg;
    logic [POS_W-1:0]      row_pos_reg;

    // Counter memory and its read port.
    cell_count_t           count_mem [NUM_CELLS];
    cell_count_t           rd_data_reg;
    logic [CELL_W-1:0]     rd_addr;
    logic [NUM_CELLS-1:0]  entry_valid_reg;

    // Increment stage.
    logic                  s1_valid_reg;
    logic [CELL_W-1:0]     s1_cell_reg;
    logic                  s1_near_reg;
    cell_count_t           s1_base;
    cell_count_t           s1_sum;
    logic                  fwd_valid_reg;
    logic [CELL_W-1:0]     fwd_cell_reg;
    cell_count_t           fwd_data_reg;

    // End-of-frame sequencer and divider.
    logic [CELL_W-1:0]     seq_cell_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      dsh_reg;
    logic [PCT_W-1:0]      quo_reg;
    logic [2:0]            step_reg;
    logic                  zero_den_reg;
    logic [PCT_W-1:0]      cell_pct;
    logic [PCT_W-1:0]      centre_pct_reg;
    logic [PCT_W-1:0]      min_pct_reg;
    logic [CELL_W-1:0]     min_cell_reg;
    cell_count_t           seq_entry;
    logic [DIV_W-1:0]      near_x100;

    // Result register.
    logic                  result_valid_reg;
    logic [CELL_W-1:0]     chosen_cell_reg;
    logic                  cell_found_reg;
    logic [PCT_W-1:0]      chosen_percent_reg;
    logic                  out_load;
    logic [CELL_W-1:0]     best_cell;
    logic [PCT_W-1:0]      best_pct;
    logic                  best_found;

    // Pixel front end.
    logic                  pix_accept;
    logic [1:0]            col_band;
    logic [1:0]            row_band;
    logic [CELL_W-1:0]     pix_cell;
    logic                  row_end;
    logic                  frame_end;
    logic                  cfg_write;
    logic [1:0]            cfg_idx;

    // Configuration port decode.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = {20'd0, width_reg};
            REG_FRAME_HEIGHT: prdata = {20'd0, height_reg};
            REG_DISP_THR:     prdata = {24'd0, disp_thr_reg};
            REG_PCT_THR:      prdata = {25'd0, pct_thr_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Register writes; the band borders are worked out as the size is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= SIZE_W'(RST_WIDTH);
            height_reg      <= SIZE_W'(RST_HEIGHT);
            disp_thr_reg    <= PIX_W'(RST_DISP_THR);
            pct_thr_reg     <= PCT_W'(RST_PCT_THR);
            col_geom_reg.last <= POS_W'(RST_WIDTH - 1);
            col_geom_reg.b1   <= POS_W'(RST_COL_B1);
            col_geom_reg.b2   <= POS_W'(RST_COL_B2);
            row_geom_reg.last <= POS_W'(RST_HEIGHT - 1);
            row_geom_reg.b1   <= POS_W'(RST_ROW_B1);
            row_geom_reg.b2   <= POS_W'(RST_ROW_B2);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_FRAME_WIDTH:
                begin
                    width_reg    <= pwdata[SIZE_W-1:0];
                    col_geom_reg <= make_geom(pwdata[SIZE_W-1:0], SIZE_W'(MAX_WIDTH));
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg   <= pwdata[SIZE_W-1:0];
                    row_geom_reg <= make_geom(pwdata[SIZE_W-1:0], SIZE_W'(MAX_HEIGHT));
                end
                REG_DISP_THR:
                begin
                    disp_thr_reg <= pwdata[PIX_W-1:0];
                end
                REG_PCT_THR:
                begin
                    pct_thr_reg  <= pwdata[PCT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Cell of the incoming pixel and end-of-row and end-of-frame detection.
    assign pixel_ready = (state_reg == S_PIXEL) && !out_phase_reg;
    assign pix_accept  = pixel_valid && pixel_ready;

    always_comb
    begin
        if (col_pos_reg < col_geom_reg.b1)
        begin
            col_band = 2'd0;
        end
        else if (col_pos_reg < col_geom_reg.b2)
        begin
            col_band = 2'd1;
        end
        else
        begin
            col_band = 2'd2;
        end
        if (row_pos_reg < row_geom_reg.b1)
        begin
            row_band = 2'd0;
        end
        else if (row_pos_reg < row_geom_reg.b2)
        begin
            row_band = 2'd1;
        end
        else
        begin
            row_band = 2'd2;
        end
        pix_cell  = {row_band, 1'b0, 1'b0} - {2'b00, row_band} + {2'b00, col_band};
        row_end   = (col_pos_reg >= col_geom_reg.last);
        frame_end = row_end && (row_pos_reg >= row_geom_reg.last);
    end

    // Raster position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (pix_accept)
        begin
            if (!row_end)
            begin
                col_pos_reg <= col_pos_reg + POS_W'(1);
            end
            else
            begin
                col_pos_reg <= '0;
                if (frame_end)
                begin
                    row_pos_reg <= '0;
                end
                else
                begin
                    row_pos_reg <= row_pos_reg + POS_W'(1);
                end
            end
        end
    end

    // Counter memory: the pixel path reads its cell, the sequencer walks the cells.
    assign rd_addr = (state_reg == S_PIXEL) ? pix_cell : seq_cell_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= count_mem[rd_addr];
        if (s1_valid_reg)
        begin
            count_mem[s1_cell_reg] <= s1_sum;
        end
    end

    // Increment stage, forwarding the write of the previous cycle.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_cell_reg == s1_cell_reg))
        begin
            s1_base = fwd_data_reg;
        end
        else if (entry_valid_reg[s1_cell_reg])
        begin
            s1_base = rd_data_reg;
        end
        else
        begin
            s1_base = '0;
        end
        s1_sum.total = s1_base.total + CNT_W'(1);
        s1_sum.near  = s1_base.near + {{(CNT_W-1){1'b0}}, s1_near_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= pix_accept;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cell_reg  <= pix_cell;
        s1_near_reg  <= (pixel_value >= disp_thr_reg);
        fwd_cell_reg <= s1_cell_reg;
        fwd_data_reg <= s1_sum;
    end

    // Entry valid bits: set on write, cleared when the frame's result is loaded into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (out_load)
        begin
            entry_valid_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            entry_valid_reg[s1_cell_reg] <= 1'b1;
        end
    end

    // Sequencer state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_PIXEL:
            begin
                if (pix_accept && frame_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == 3'd6)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                if (seq_cell_reg == LAST_CELL)
                begin
                    state_next = S_PIXEL;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_PIXEL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_PIXEL;
            out_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_SEL) && (seq_cell_reg == LAST_CELL))
            begin
                out_phase_reg <= 1'b1;
            end
            else if (out_load)
            begin
                out_phase_reg <= 1'b0;
            end
        end
    end

    // Divider operands for the cell being read.
    assign seq_entry = entry_valid_reg[seq_cell_reg] ? rd_data_reg : '0;
    assign near_x100 = {1'b0, seq_entry.near, 6'd0} + {2'b00, seq_entry.near, 5'd0}
                     + {5'd0, seq_entry.near, 2'd0};
    assign cell_pct  = zero_den_reg ? FULL_PCT : quo_reg;

    // Percentage by restoring division, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_DRAIN:
            begin
                seq_cell_reg <= '0;
            end
            S_LOAD:
            begin
                rem_reg      <= near_x100;
                dsh_reg      <= {1'b0, seq_entry.total, 6'd0};
                zero_den_reg <= (seq_entry.total == '0);
                quo_reg      <= '0;
                step_reg     <= '0;
            end
            S_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    quo_reg <= {quo_reg[PCT_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[PCT_W-2:0], 1'b0};
                end
                dsh_reg  <= {1'b0, dsh_reg[DIV_W-1:1]};
                step_reg <= step_reg + 3'd1;
            end
            S_SEL:
            begin
                // The centre is kept apart; other cells keep the first strict minimum.
                if (seq_cell_reg == CENTRE_CELL)
                begin
                    centre_pct_reg <= cell_pct;
                end
                else if ((seq_cell_reg == '0) || (cell_pct < min_pct_reg))
                begin
                    min_pct_reg  <= cell_pct;
                    min_cell_reg <= seq_cell_reg;
                end
                seq_cell_reg <= seq_cell_reg + CELL_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Final choice: centre first, else the lower of the other cells wins only if strictly lower.
    always_comb
    begin
        if (centre_pct_reg < pct_thr_reg)
        begin
            best_cell = CENTRE_CELL;
            best_pct  = centre_pct_reg;
        end
        else if (min_pct_reg < centre_pct_reg)
        begin
            best_cell = min_cell_reg;
            best_pct  = min_pct_reg;
        end
        else
        begin
            best_cell = CENTRE_CELL;
            best_pct  = centre_pct_reg;
        end
        best_found = (best_pct < pct_thr_reg);
    end

    // Result register.
    assign out_load = out_phase_reg && (!result_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            chosen_cell_reg    <= best_found ? best_cell : '0;
            cell_found_reg     <= best_found;
            chosen_percent_reg <= best_pct;
        end
    end

    assign result_valid   = result_valid_reg;
    assign chosen_cell    = chosen_cell_reg;
    assign cell_found     = cell_found_reg;
    assign chosen_percent = chosen_percent_reg;

endmodule
